// ----- hdl/assert_macros.svh -----
// assertion macros shared by the governor modules
// no dependencies; each macro checks one clocked implication with async reset gating
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/ccedf_pkg.sv -----
// shared constants and controller/datapath interface types for the governor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ccedf_pkg;

	localparam int CFG_W              = 5;
	localparam int SLOT_W             = 4;
	localparam int TIME_W             = 16;
	localparam int LEVEL_W            = 3;
	localparam int TENTHS_W           = 4;
	localparam int REQ_UTIL_W         = 21;
	localparam int FULL_TENTHS        = 10;
	localparam int SLOWEST_TENTHS     = 4;
	localparam int TASK_SLOTS_DEF     = 16;
	localparam int UTIL_FRAC_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] TASK_COUNT_RST = 5'd16;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic write;
		logic sum_issue;
		logic commit;
		logic pick;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic err;
		logic sat;
		logic sweep_last;
	} sts_t;

endpackage

`default_nettype wire

// ----- hdl/ccedf_speed_governor.sv -----
// top level of the cycle-conserving edf speed governor
// depends on ccedf_pkg, ccedf_ctrl, ccedf_dp and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// usage
//  - an item (release or completion event) is taken on a rising edge with start high and
//    busy low; start while busy is ignored
//  - release and completion items update the slot the same way, so mode only labels the item
//  - each item gives one result, shown for exactly one cycle with done high; the receiver
//    cannot stall, so results must be captured on that cycle
//  - steps from the accepting edge to the done cycle:
//      rejected item (bad slot or zero period): check, pick
//      saturated item (time at or above period): check, write, sweep, drain, commit, pick
//      other items: check, divide, write, sweep, drain, commit, pick
//    where the sweep reads the N active slots (min of task_count and TASK_SLOTS)
//  - the serial divider (one quotient bit a cycle) and the slot sweep (one memory read a
//    cycle through the single read port) do the divide and sweep steps
//  - busy falls in the done cycle, so the next item may be taken there; no new item is
//    taken while an earlier item is still in work
//  - write task_count through cfg_wr_en / cfg_wr_data while idle; nothing enforces it
//  - reset: task_count returns to 16, all utilizations read as zero through per-slot
//    valid bits, the running total is zero; no clearing pass is needed

module ccedf_speed_governor #(
	parameter int TASK_SLOTS     = ccedf_pkg::TASK_SLOTS_DEF,
	parameter int UTIL_FRAC_BITS = ccedf_pkg::UTIL_FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// config register
	input  wire                                  cfg_wr_en,
	input  wire  [ccedf_pkg::CFG_W-1:0]          cfg_wr_data,
	// item in
	input  wire                                  start,
	input  wire                                  mode,
	input  wire  [ccedf_pkg::SLOT_W-1:0]         task_slot,
	input  wire  [ccedf_pkg::TIME_W-1:0]         exec_time,
	input  wire  [ccedf_pkg::TIME_W-1:0]         task_period,
	output logic                                 busy,
	// result out
	output logic                                 done,
	output logic [ccedf_pkg::LEVEL_W-1:0]        freq_level,
	output logic [ccedf_pkg::TENTHS_W-1:0]       speed_tenths,
	output logic [ccedf_pkg::REQ_UTIL_W-1:0]     util_demand,
	output logic                                 error
);

	// command and status between sequencer and datapath
	ccedf_pkg::cmd_t cmd;
	ccedf_pkg::sts_t sts;

	// sequencer: check, divide, write, sweep, commit, pick
	ccedf_ctrl #(
		.UTIL_FRAC_BITS (UTIL_FRAC_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: divider, utilization store, accumulator and speed choice
	ccedf_dp #(
		.TASK_SLOTS     (TASK_SLOTS),
		.UTIL_FRAC_BITS (UTIL_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.task_slot     (task_slot),
		.exec_time     (exec_time),
		.task_period   (task_period),
		.cmd           (cmd),
		.sts           (sts),
		.freq_level    (freq_level),
		.speed_tenths  (speed_tenths),
		.util_demand   (util_demand),
		.error         (error)
	);

	// an accepted item carries no unknown bits
	`ASSERT_IMPLIES(a_item_known, clk, arst_n, start && !busy, !$isunknown({mode, task_slot, exec_time, task_period}))

endmodule

`default_nettype wire

// ----- hdl/ccedf_ctrl.sv -----
// sequencing state machine for the governor
// depends on ccedf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ccedf_ctrl #(
	parameter int UTIL_FRAC_BITS = ccedf_pkg::UTIL_FRAC_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  ccedf_pkg::sts_t  sts,
	output ccedf_pkg::cmd_t  cmd,
	output logic             busy,
	output logic             done
);

	localparam int DCW = $clog2(UTIL_FRAC_BITS);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(UTIL_FRAC_BITS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_WRITE,
		S_SUM,
		S_DRAIN,
		S_COMMIT,
		S_PICK
	} state_t;

	state_t          state_q;
	logic [DCW-1:0]  div_cnt_q;
	logic            busy_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
						busy_q  <= 1'b1;
					end
				end
				S_CHECK: begin
					div_cnt_q <= '0;
					if (sts.err) begin
						state_q <= S_PICK;
					end else if (sts.sat) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (sts.sweep_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.div_step  = (state_q == S_DIV);
		cmd.write     = (state_q == S_WRITE);
		cmd.sum_issue = (state_q == S_SUM);
		cmd.commit    = (state_q == S_COMMIT);
		cmd.pick      = (state_q == S_PICK);
	end

	assign busy = busy_q;
	assign done = done_q;

	`ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, done_q, !busy_q)
	`ASSERT_NEXT(a_start_sets_busy, clk, arst_n, start && !busy_q, busy_q && !done_q)

endmodule

`default_nettype wire

// ----- hdl/ccedf_dp.sv -----
// datapath: serial divider, utilization memory, sweep accumulator, speed pick
// depends on ccedf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ccedf_dp #(
	parameter int TASK_SLOTS     = ccedf_pkg::TASK_SLOTS_DEF,
	parameter int UTIL_FRAC_BITS = ccedf_pkg::UTIL_FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [ccedf_pkg::CFG_W-1:0]          cfg_wr_data,
	input  wire  [ccedf_pkg::SLOT_W-1:0]         task_slot,
	input  wire  [ccedf_pkg::TIME_W-1:0]         exec_time,
	input  wire  [ccedf_pkg::TIME_W-1:0]         task_period,
	input  ccedf_pkg::cmd_t                      cmd,
	output ccedf_pkg::sts_t                      sts,
	output logic [ccedf_pkg::LEVEL_W-1:0]        freq_level,
	output logic [ccedf_pkg::TENTHS_W-1:0]       speed_tenths,
	output logic [ccedf_pkg::REQ_UTIL_W-1:0]     util_demand,
	output logic                                 error
);

	localparam int UF     = UTIL_FRAC_BITS;
	localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
	localparam int CMP_W  = (CNT_W > ccedf_pkg::CFG_W) ? CNT_W : ccedf_pkg::CFG_W;
	localparam int TOT_W  = UF + 1 + $clog2(TASK_SLOTS);
	localparam int MW     = TOT_W + 4;
	localparam int REM_W  = ccedf_pkg::TIME_W + 1;
	localparam int REQ_W  = ccedf_pkg::REQ_UTIL_W;

	localparam logic [UF:0] UTIL_ONE = {1'b1, {UF{1'b0}}};

	// config and latched item
	logic [ccedf_pkg::CFG_W-1:0]  task_count_q;
	logic [CMP_W-1:0]             slot_q;
	logic [ccedf_pkg::TIME_W-1:0] period_q;
	logic                         err_q;
	logic                         sat_q;

	// divider
	logic [REM_W-1:0] rem_q;
	logic [UF:0]      quot_q;
	logic [REM_W-1:0] rem_shl;
	logic             quot_bit;

	// utilization store
	logic [UF:0]            util_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]  valid_q;
	logic [CMP_W-1:0]       ptr_q;
	logic [IDX_W-1:0]       rd_addr;
	logic [IDX_W-1:0]       wr_addr;
	logic [UF:0]            rd_data_s1;
	logic                   rd_hit_s1;
	logic                   rd_vld_s1;

	// sums and result
	logic [CMP_W-1:0]  eff_cnt;
	logic [TOT_W-1:0]  acc_q;
	logic [TOT_W-1:0]  total_q;
	logic [MW-1:0]     ten_sum;
	logic [ccedf_pkg::LEVEL_W-1:0] level;
	logic [TOT_W+REQ_W-1:0]        total_ext;

	logic [ccedf_pkg::LEVEL_W-1:0]  level_q;
	logic [ccedf_pkg::TENTHS_W-1:0] tenths_q;
	logic [REQ_W-1:0]               req_q;
	logic                           error_q;

	// slots beyond the store act as the store size
	assign eff_cnt = (CMP_W'(task_count_q) >= CMP_W'(TASK_SLOTS)) ?
		CMP_W'(TASK_SLOTS) : CMP_W'(task_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= ccedf_pkg::TASK_COUNT_RST;
		end else if (cfg_wr_en) begin
			task_count_q <= cfg_wr_data;
		end
	end

	// item latch and error / saturation checks
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q   <= CMP_W'(task_slot);
			period_q <= task_period;
			err_q    <= (CMP_W'(task_slot) >= eff_cnt) || (task_period == '0);
			sat_q    <= (exec_time >= task_period);
		end
	end

	// restoring division, one quotient bit per step; time below period here
	assign rem_shl  = {rem_q[REM_W-2:0], 1'b0};
	assign quot_bit = (rem_shl >= REM_W'(period_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= REM_W'(exec_time);
			quot_q <= (exec_time >= task_period) ? UTIL_ONE : '0;
		end else if (cmd.div_step) begin
			rem_q  <= quot_bit ? (rem_shl - REM_W'(period_q)) : rem_shl;
			quot_q <= {quot_q[UF-1:0], quot_bit};
		end
	end

	assign wr_addr = slot_q[IDX_W-1:0];
	assign rd_addr = ptr_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			util_mem[wr_addr] <= quot_q;
		end
		rd_data_s1 <= util_mem[rd_addr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_hit_s1 <= 1'b0;
			rd_vld_s1 <= 1'b0;
			ptr_q     <= '0;
		end else begin
			if (cmd.write) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_hit_s1 <= valid_q[rd_addr];
			rd_vld_s1 <= cmd.sum_issue;
			if (cmd.write) begin
				ptr_q <= '0;
			end else if (cmd.sum_issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign sts.err        = err_q;
	assign sts.sat        = sat_q;
	assign sts.sweep_last = ((ptr_q + 1'b1) == eff_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.write) begin
				acc_q <= '0;
			end else if (rd_vld_s1 && rd_hit_s1) begin
				acc_q <= acc_q + TOT_W'(rd_data_s1);
			end
			if (cmd.commit) begin
				total_q <= acc_q;
			end
		end
	end

	// slowest speed with 10*sum <= tenths*one, else full speed
	assign ten_sum = (MW'(total_q) << 3) + (MW'(total_q) << 1);

	always_comb begin
		level = '0;
		for (int t = ccedf_pkg::FULL_TENTHS; t >= ccedf_pkg::SLOWEST_TENTHS; t--) begin
			if (ten_sum <= (MW'(t) << UF)) begin
				level = ccedf_pkg::LEVEL_W'(ccedf_pkg::FULL_TENTHS - t);
			end
		end
	end

	assign total_ext = {{REQ_W{1'b0}}, total_q};

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			level_q  <= level;
			tenths_q <= ccedf_pkg::TENTHS_W'(ccedf_pkg::FULL_TENTHS) -
				ccedf_pkg::TENTHS_W'(level);
			req_q    <= total_ext[REQ_W-1:0];
			error_q  <= err_q;
		end
	end

	assign freq_level    = level_q;
	assign speed_tenths  = tenths_q;
	assign util_demand   = req_q;
	assign error         = error_q;

	`ASSERT_IMPLIES(a_write_only_valid, clk, arst_n, cmd.write, !err_q && (slot_q < eff_cnt))
	`ASSERT_IMPLIES(a_div_not_sat, clk, arst_n, cmd.div_step, !sat_q && !err_q)

endmodule

`default_nettype wire

// ----- test/ccedf_speed_governor_test.sv -----
// self-checking testbench for the cycle-conserving edf speed governor
// depends on ccedf_pkg and ccedf_speed_governor; carries its own model of the utilization store
`timescale 1ns / 1ps

module ccedf_speed_governor_test;

	import ccedf_pkg::*;

	// event kinds; both update the slot the same way
	localparam logic MODE_RELEASE  = 1'b0;
	localparam logic MODE_COMPLETE = 1'b1;

	localparam int          SLOT_COUNT  = TASK_SLOTS_DEF;
	localparam int          FRAC_BITS   = UTIL_FRAC_BITS_DEF;
	localparam logic [32:0] UTIL_ONE    = 33'd1 << FRAC_BITS;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          DRAIN_WAIT  = 60;

	typedef struct packed {
		logic [LEVEL_W-1:0]    level;
		logic [TENTHS_W-1:0]   tenths;
		logic [REQ_UTIL_W-1:0] util;
		logic                  err;
	} speed_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic start;
	logic mode;
	logic [SLOT_W-1:0] task_slot;
	logic [TIME_W-1:0] exec_time;
	logic [TIME_W-1:0] task_period;
	logic busy;
	logic done;
	logic [LEVEL_W-1:0] freq_level;
	logic [TENTHS_W-1:0] speed_tenths;
	logic [REQ_UTIL_W-1:0] util_demand;
	logic error;

	// model of the block: per-slot utilization, running total and slot count register
	logic [16:0]           slot_util [SLOT_COUNT];
	logic [REQ_UTIL_W-1:0] shadow_total;
	logic [CFG_W-1:0]      active_count;

	speed_result_t expected_speed_q [$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;

	ccedf_speed_governor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.start         (start),
		.mode          (mode),
		.task_slot     (task_slot),
		.exec_time     (exec_time),
		.task_period   (task_period),
		.busy          (busy),
		.done          (done),
		.freq_level    (freq_level),
		.speed_tenths  (speed_tenths),
		.util_demand   (util_demand),
		.error         (error)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// slowest speed whose capacity covers the demand; full speed when none does
	function automatic logic [LEVEL_W-1:0] level_for_util(logic [REQ_UTIL_W-1:0] demand);
		logic [LEVEL_W-1:0] lvl;
		longint unsigned scaled;
		lvl = '0;
		scaled = 64'(demand) * 10;
		// walk from full speed downwards, the last speed that fits wins
		for (int t = FULL_TENTHS; t >= SLOWEST_TENTHS; t--) begin
			if (scaled <= (64'(t) << FRAC_BITS))
				lvl = LEVEL_W'(FULL_TENTHS - t);
		end
		return lvl;
	endfunction

	// apply one event to the model and give back the speed choice it leads to
	function automatic speed_result_t governor_update(logic [SLOT_W-1:0] slot,
			logic [TIME_W-1:0] ticks, logic [TIME_W-1:0] period);
		speed_result_t res;
		int unsigned slots_live;
		logic [32:0] quot;
		logic [REQ_UTIL_W-1:0] acc;
		slots_live = (active_count > SLOT_COUNT) ? SLOT_COUNT : active_count;
		res.err = (slot >= slots_live) || (period == '0);
		// rejected events leave the store and total alone
		if (!res.err) begin
			quot = {1'b0, ticks, 16'b0} / {17'b0, period};
			// anything above one is held at exactly one
			if (quot > UTIL_ONE)
				quot = UTIL_ONE;
			slot_util[slot] = quot[16:0];
			acc = '0;
			for (int i = 0; i < slots_live; i++)
				acc += REQ_UTIL_W'(slot_util[i]);
			shadow_total = acc;
		end
		res.level = level_for_util(shadow_total);
		res.tenths = TENTHS_W'(FULL_TENTHS) - TENTHS_W'(res.level);
		res.util = shadow_total;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		mismatch_count++;
	endtask

	// result checker: the receiver never stalls, so every done cycle is one result
	always @(posedge clk) begin
		speed_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_speed_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", 0, 0);
			end else begin
				want = expected_speed_q.pop_front();
				if (freq_level !== want.level)
					report_mismatch("freq_level", want.level, freq_level);
				if (speed_tenths !== want.tenths)
					report_mismatch("speed_tenths", want.tenths, speed_tenths);
				if (util_demand !== want.util)
					report_mismatch("util_demand", want.util, util_demand);
				if (error !== want.err)
					report_mismatch("error", want.err, error);
			end
		end
	end

	// present one item and hold it until taken; start is left high for a following item
	task automatic send_item(logic ev_mode, logic [SLOT_W-1:0] slot,
			logic [TIME_W-1:0] ticks, logic [TIME_W-1:0] period);
		start <= 1'b1;
		mode <= ev_mode;
		task_slot <= slot;
		exec_time <= ticks;
		task_period <= period;
		// start raised while busy is ignored, so keep it up until busy is seen low
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_speed_q.push_back(governor_update(slot, ticks, period));
	endtask

	task automatic idle_cycles(int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for every outstanding result, then write the slot count
	task automatic write_task_count(logic [CFG_W-1:0] value);
		start <= 1'b0;
		while (expected_speed_q.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		active_count = value;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// fresh store reads as zero everywhere
	task automatic test_reset_state();
		write_task_count(5'd16);
		send_item(MODE_RELEASE, 4'd7, 16'd0, 16'd1);
		send_item(MODE_COMPLETE, 4'd12, 16'd0, 16'hFFFF);
	endtask

	// field extremes, exact one, saturation and the no-speed-fits fallback
	task automatic test_field_extremes();
		send_item(MODE_RELEASE, 4'd0, 16'd1, 16'hFFFF);
		send_item(MODE_COMPLETE, 4'd15, 16'hFFFF, 16'hFFFF);
		// time far above the period saturates at one
		send_item(MODE_RELEASE, 4'd3, 16'hFFFF, 16'd1);
		// that leaves two slots at one: no speed suffices; slot 3 then goes back to zero
		send_item(MODE_COMPLETE, 4'd3, 16'd0, 16'd7);
		send_item(MODE_RELEASE, 4'd15, 16'd6, 16'd10);
		send_item(MODE_COMPLETE, 4'd15, 16'd40000, 16'd39999);
		send_item(MODE_RELEASE, 4'd8, 16'h5555, 16'hAAAA);
		send_item(MODE_COMPLETE, 4'd15, 16'd1, 16'd3);
		send_item(MODE_RELEASE, 4'd0, 16'd0, 16'h8000);
		send_item(MODE_RELEASE, 4'd8, 16'd0, 16'h0001);
	endtask

	// zero period and out-of-range slots report the stored total untouched
	task automatic test_rejected_events();
		send_item(MODE_RELEASE, 4'd5, 16'hFFFF, 16'd0);
		send_item(MODE_COMPLETE, 4'd0, 16'd0, 16'd0);
		write_task_count(5'd4);
		send_item(MODE_RELEASE, 4'd4, 16'd100, 16'd200);
		send_item(MODE_COMPLETE, 4'd15, 16'd100, 16'd200);
		send_item(MODE_RELEASE, 4'd3, 16'd1, 16'd4);
		// no slots in use: everything is rejected
		write_task_count(5'd0);
		send_item(MODE_RELEASE, 4'd0, 16'd10, 16'd20);
	endtask

	// a lowered count hides upper slots, a raised one brings them back
	task automatic test_task_count_changes();
		write_task_count(5'd31);
		send_item(MODE_RELEASE, 4'd15, 16'd3, 16'd10);
		write_task_count(5'd2);
		send_item(MODE_COMPLETE, 4'd1, 16'd1, 16'd10);
		send_item(MODE_RELEASE, 4'd2, 16'd1, 16'd10);
		write_task_count(5'd16);
		send_item(MODE_COMPLETE, 4'd0, 16'd2, 16'd10);
	endtask

	// mostly well-formed events with a load level that drifts through all speeds
	task automatic test_random_traffic(logic [CFG_W-1:0] count_cfg, int unsigned n_items,
			bit with_gaps);
		int unsigned slots_live;
		int unsigned load_k;
		int unsigned pick;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] ticks;
		logic [TIME_W-1:0] period;
		longint unsigned scaled;
		write_task_count(count_cfg);
		slots_live = (count_cfg > SLOT_COUNT) ? SLOT_COUNT : count_cfg;
		load_k = 0;
		for (int n = 0; n < n_items; n++) begin
			// retarget the total load every so often, in 1/1024 steps per slot
			if (n % 40 == 0)
				load_k = $urandom_range(300, 1500) / (slots_live == 0 ? 1 : slots_live);
			pick = $urandom_range(0, 99);
			if (pick < 8 || slots_live == 0) begin
				// broken event: zero period, or a slot past the count where one exists
				slot = (slots_live < SLOT_COUNT && pick[0]) ?
					SLOT_W'($urandom_range(slots_live, SLOT_COUNT - 1)) : SLOT_W'($urandom);
				ticks = TIME_W'($urandom);
				period = (slots_live < SLOT_COUNT && pick[0]) ? TIME_W'($urandom) : '0;
			end else if (pick < 20) begin
				// raw noise over the whole field ranges
				slot = SLOT_W'($urandom);
				ticks = TIME_W'($urandom);
				period = TIME_W'($urandom);
			end else begin
				slot = SLOT_W'($urandom_range(0, slots_live - 1));
				period = pick[1] ? TIME_W'($urandom_range(1, 255)) :
					TIME_W'($urandom_range(1, 65535));
				scaled = (64'(period) * $urandom_range(0, 2 * load_k + 1)) >> 10;
				ticks = (scaled > 65535) ? 16'hFFFF : TIME_W'(scaled);
			end
			send_item(logic'($urandom_range(0, 1)), slot, ticks, period);
			// gaps of random length so they land anywhere in the block's work
			if (with_gaps && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 17));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		mode = MODE_RELEASE;
		task_slot = '0;
		exec_time = '0;
		task_period = '0;
		for (int i = 0; i < SLOT_COUNT; i++)
			slot_util[i] = '0;
		shadow_total = '0;
		active_count = TASK_COUNT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_rejected_events();
		test_task_count_changes();

		test_random_traffic(5'd16, 300, 1'b1);
		test_random_traffic(5'd31, 200, 1'b1);
		test_random_traffic(5'd1, 150, 1'b1);
		test_random_traffic(CFG_W'($urandom_range(2, 15)), 250, 1'b1);
		test_random_traffic(CFG_W'($urandom_range(1, 31)), 200, 1'b1);
		// closing stretch runs back to back with no gaps
		test_random_traffic(5'd16, 200, 1'b0);

		// drain the last results, then allow for any stray extra one
		start <= 1'b0;
		while (expected_speed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
